[rtl/ukd_pkg.sv]
// Shared types and codes for the unique-key deque.
// Depends on nothing; the core and the testbench import it.
package ukd_pkg;

    localparam int OP_W   = 2;
    localparam int ST_W   = 3;
    localparam int WORD_W = 32;

    // Operation codes carried in the request tuser.
    localparam logic [OP_W-1:0] OP_APPEND  = 2'd0;
    localparam logic [OP_W-1:0] OP_PREPEND = 2'd1;
    localparam logic [OP_W-1:0] OP_DISPLAY = 2'd2;

    // Status codes carried in the result tuser.
    localparam logic [ST_W-1:0] ST_APPENDED  = 3'd0;
    localparam logic [ST_W-1:0] ST_PREPENDED = 3'd1;
    localparam logic [ST_W-1:0] ST_DUPLICATE = 3'd2;
    localparam logic [ST_W-1:0] ST_FULL      = 3'd3;
    localparam logic [ST_W-1:0] ST_EMPTY     = 3'd4;
    localparam logic [ST_W-1:0] ST_SHOWN     = 3'd5;

endpackage

[rtl/unique_key_deque_core.sv]
// Top level of the unique-key deque: sequencer, pointers and result register.
// Depends on ukd_pkg and ukd_ram.
//
// Usage:
// Requests arrive on the s_ channel. s_tuser carries the operation (append at
// tail, prepend at head, display all), s_tdata carries key and data. Results
// leave on the m_ channel: m_tuser carries the status, m_tdata the key and data
// of a shown entry (zero otherwise), and m_tlast marks the final result of a
// request. An insert gives exactly one result; a display gives one result per
// stored entry from head to tail, or a single empty status.
//
// Timing: an insert walks the stored keys through one shared 32-bit compare,
// one key per cycle behind the registered memory read. Its result is loaded
// in S_FIN once the result register is free, and the sequencer then returns
// to idle for the next request. A display loads each result in two steps
// (memory read in S_DRD, then result register in S_DOUT), waiting in S_DOUT
// while the receiver stalls. One request is handled at a time; s_tready is
// high only while the sequencer is idle, even when a result still waits in
// the output register.
//
// Reset clears head, count, sequencer and result valid; stored entries are not
// cleared and no clearing pass runs. When the receiver stalls, the result
// register holds its contents and the sequencer waits before loading the next.
module unique_key_deque_core #(
    parameter int DEPTH = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // s_tdata: key [31:0], value [63:32]
    input  logic [2*ukd_pkg::WORD_W-1:0]  s_tdata,
    // s_tuser: op [1:0]
    input  logic [ukd_pkg::OP_W-1:0]      s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // m_tdata: out_key [31:0], out_value [63:32]
    output logic [2*ukd_pkg::WORD_W-1:0]  m_tdata,
    // m_tuser: status [2:0]
    output logic [ukd_pkg::ST_W-1:0]      m_tuser,
    output logic                          m_tlast
);

    import ukd_pkg::*;

    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int SUM_W = CNT_W + 1;

    // Sequencer states.
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SCAN = 3'd1;
    localparam logic [2:0] S_FIN  = 3'd2;
    localparam logic [2:0] S_DRD  = 3'd3;
    localparam logic [2:0] S_DOUT = 3'd4;

    logic [2:0]        state_reg, state_next;
    logic [IDX_W-1:0]  head_reg, head_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [CNT_W-1:0]  pos_reg, pos_next;
    logic [IDX_W-1:0]  ptr_reg, ptr_next;
    logic              rd_vld_reg, rd_vld_next;
    logic              found_reg, found_next;
    logic [OP_W-1:0]   op_reg, op_next;
    logic [WORD_W-1:0] key_reg, key_next;
    logic [WORD_W-1:0] value_reg, value_next;
    logic [ST_W-1:0]   res_reg, res_next;

    logic              out_valid_reg, out_valid_next;
    logic [ST_W-1:0]   out_status_reg, out_status_next;
    logic [WORD_W-1:0] out_key_reg, out_key_next;
    logic [WORD_W-1:0] out_value_reg, out_value_next;
    logic              out_last_reg, out_last_next;

    logic                ram_we;
    logic [IDX_W-1:0]    ram_waddr;
    logic                ram_re;
    logic [2*WORD_W-1:0] ram_rdata;
    logic [WORD_W-1:0]   rd_key;
    logic [WORD_W-1:0]   rd_value;

    logic [SUM_W-1:0]  tail_sum;
    logic [IDX_W-1:0]  tail_slot;
    logic [IDX_W-1:0]  prev_head;
    logic [IDX_W-1:0]  ptr_inc;
    logic              out_free;

    ukd_ram #(
        .DEPTH (DEPTH),
        .WIDTH (2 * WORD_W)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata ({value_reg, key_reg}),
        .re    (ram_re),
        .raddr (ptr_reg),
        .rdata (ram_rdata)
    );

    assign rd_key   = ram_rdata[WORD_W-1:0];
    assign rd_value = ram_rdata[2*WORD_W-1:WORD_W];

    // The tail slot is head + count folded once into the ring.
    assign tail_sum  = SUM_W'(head_reg) + SUM_W'(cnt_reg);
    assign tail_slot = (tail_sum >= SUM_W'(DEPTH)) ? IDX_W'(tail_sum - SUM_W'(DEPTH))
                                                   : IDX_W'(tail_sum);
    assign prev_head = (head_reg == '0) ? IDX_W'(DEPTH - 1) : head_reg - IDX_W'(1);
    assign ptr_inc   = (ptr_reg == IDX_W'(DEPTH - 1)) ? '0 : ptr_reg + IDX_W'(1);
    assign out_free  = !out_valid_reg || m_tready;

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_value_reg, out_key_reg};
    assign m_tuser  = out_status_reg;
    assign m_tlast  = out_last_reg;

    always_comb
    begin
        state_next      = state_reg;
        head_next       = head_reg;
        cnt_next        = cnt_reg;
        pos_next        = pos_reg;
        ptr_next        = ptr_reg;
        rd_vld_next     = 1'b0;
        found_next      = found_reg;
        op_next         = op_reg;
        key_next        = key_reg;
        value_next      = value_reg;
        res_next        = res_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_status_next = out_status_reg;
        out_key_next    = out_key_reg;
        out_value_next  = out_value_reg;
        out_last_next   = out_last_reg;
        ram_we          = 1'b0;
        ram_waddr       = tail_slot;
        ram_re          = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    op_next    = s_tuser;
                    key_next   = s_tdata[WORD_W-1:0];
                    value_next = s_tdata[2*WORD_W-1:WORD_W];
                    pos_next   = '0;
                    ptr_next   = head_reg;
                    found_next = 1'b0;
                    case (s_tuser)
                        OP_APPEND, OP_PREPEND:
                        begin
                            state_next = S_SCAN;
                        end
                        OP_DISPLAY:
                        begin
                            if (cnt_reg == '0)
                            begin
                                res_next   = ST_EMPTY;
                                state_next = S_FIN;
                            end
                            else
                            begin
                                state_next = S_DRD;
                            end
                        end
                        default:
                        begin
                            // The unused operation is dropped without a result.
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                // Compare the key read in the previous cycle.
                if (rd_vld_reg && (rd_key == key_reg))
                begin
                    found_next = 1'b1;
                end
                if (pos_reg != cnt_reg)
                begin
                    ram_re      = 1'b1;
                    rd_vld_next = 1'b1;
                    pos_next    = pos_reg + CNT_W'(1);
                    ptr_next    = ptr_inc;
                end
                else if (!rd_vld_reg)
                begin
                    state_next = S_FIN;
                    if (found_reg)
                    begin
                        res_next = ST_DUPLICATE;
                    end
                    else if (cnt_reg == CNT_W'(DEPTH))
                    begin
                        res_next = ST_FULL;
                    end
                    else
                    begin
                        ram_we   = 1'b1;
                        cnt_next = cnt_reg + CNT_W'(1);
                        if (op_reg == OP_APPEND)
                        begin
                            res_next = ST_APPENDED;
                        end
                        else
                        begin
                            ram_waddr = prev_head;
                            head_next = prev_head;
                            res_next  = ST_PREPENDED;
                        end
                    end
                end
            end
            S_FIN:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_reg;
                    out_key_next    = '0;
                    out_value_next  = '0;
                    out_last_next   = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            S_DRD:
            begin
                ram_re     = 1'b1;
                state_next = S_DOUT;
            end
            S_DOUT:
            begin
                // Read data stays put until the next read, so a stall is safe here.
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = ST_SHOWN;
                    out_key_next    = rd_key;
                    out_value_next  = rd_value;
                    out_last_next   = ((pos_reg + CNT_W'(1)) == cnt_reg);
                    pos_next        = pos_reg + CNT_W'(1);
                    ptr_next        = ptr_inc;
                    state_next      = ((pos_reg + CNT_W'(1)) == cnt_reg) ? S_IDLE : S_DRD;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            head_reg      <= '0;
            cnt_reg       <= '0;
            pos_reg       <= '0;
            ptr_reg       <= '0;
            rd_vld_reg    <= 1'b0;
            found_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            cnt_reg       <= cnt_next;
            pos_reg       <= pos_next;
            ptr_reg       <= ptr_next;
            rd_vld_reg    <= rd_vld_next;
            found_reg     <= found_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        key_reg        <= key_next;
        value_reg      <= value_next;
        res_reg        <= res_next;
        out_status_reg <= out_status_next;
        out_key_reg    <= out_key_next;
        out_value_reg  <= out_value_next;
        out_last_reg   <= out_last_next;
    end

    // The entry count never passes the ring size.
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(DEPTH))
        else $error("entry count above depth");

    // A store only happens for a new key with room left.
    a_write_ok: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (!found_reg && (cnt_reg < CNT_W'(DEPTH)) && (state_reg == S_SCAN)))
        else $error("entry written for duplicate key or full deque");

    // Only shown entries of a display may come without the last mark.
    a_mid_shown: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tlast) |-> (m_tuser == ST_SHOWN))
        else $error("non-final result that is not a shown entry");

    // A pending key compare belongs to the duplicate scan.
    a_scan_read: assert property (@(posedge clk) disable iff (!rst_n)
        rd_vld_reg |-> (state_reg == S_SCAN))
        else $error("key compare outside the scan");

endmodule

[rtl/ukd_ram.sv]
// Simple dual-port entry store: one write port and one registered read port.
// Depends on nothing.
module ukd_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

[sim/tb_unique_key_deque_core.sv]
// Self-checking testbench for unique_key_deque_core: directed tests, then random traffic.
// Depends on ukd_pkg and the deque RTL; a behavioral deque model predicts every result.
module tb_unique_key_deque_core;

    import ukd_pkg::*;

    localparam int QDEPTH = 16;
    localparam int HEAD_W = $clog2(QDEPTH);
    // Any stall-free run finishes well inside this many cycles; it is a hang guard only.
    localparam int CYCLE_LIMIT = 300000;
    // Longest quiet stretch the block needs after the last result: a full display.
    localparam int DRAIN_CYCLES = 4 * QDEPTH + 16;
    // The fourth code of the op field has no function and must be ignored.
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    typedef struct packed {
        logic [ST_W-1:0]   status;
        logic [WORD_W-1:0] key;
        logic [WORD_W-1:0] value;
        logic              last;
    } deque_result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [2*WORD_W-1:0]   s_tdata = '0;
    logic [OP_W-1:0]       s_tuser = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [2*WORD_W-1:0]   m_tdata;
    logic [ST_W-1:0]       m_tuser;
    logic                  m_tlast;

    // Mirror of the deque contents, kept in step with every accepted request.
    logic [WORD_W-1:0] mirror_keys [QDEPTH];
    logic [WORD_W-1:0] mirror_values [QDEPTH];
    logic [HEAD_W-1:0] mirror_head = '0;
    int                mirror_count = 0;

    // Results the block still owes, oldest first.
    deque_result_t awaited_results [$];

    int  error_count = 0;
    int  cycle_count = 0;
    int  ready_stall_left = 0;
    bit  idling_enabled = 1'b0;

    unique_key_deque_core #(
        .DEPTH(QDEPTH)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Hang guard: a block that stops answering ends the run as a failure.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Receiver side: ready drops in bursts of random length while idling is on.
    always @(posedge clk)
    begin
        if (ready_stall_left != 0)
        begin
            m_tready <= 1'b0;
            ready_stall_left <= ready_stall_left - 1;
        end
        else if (idling_enabled && $urandom_range(0, 4) == 0)
        begin
            m_tready <= 1'b0;
            ready_stall_left <= $urandom_range(0, 6);
        end
        else
        begin
            m_tready <= 1'b1;
        end
    end

    // Every result taken by the receiver is matched against the oldest prediction.
    // Signals are read right at the edge, so they hold the values the handshake saw.
    always @(posedge clk)
    begin
        deque_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (awaited_results.size() == 0)
            begin
                $error("unexpected result: status %0d data %h last %b",
                       m_tuser, m_tdata, m_tlast);
                error_count++;
            end
            else
            begin
                want = awaited_results.pop_front();
                if (m_tuser !== want.status)
                begin
                    $error("status: expected %0d, got %0d", want.status, m_tuser);
                    error_count++;
                end
                if (m_tdata[WORD_W-1:0] !== want.key)
                begin
                    $error("out_key: expected %h, got %h", want.key, m_tdata[WORD_W-1:0]);
                    error_count++;
                end
                if (m_tdata[2*WORD_W-1:WORD_W] !== want.value)
                begin
                    $error("out_value: expected %h, got %h",
                           want.value, m_tdata[2*WORD_W-1:WORD_W]);
                    error_count++;
                end
                if (m_tlast !== want.last)
                begin
                    $error("last: expected %b, got %b", want.last, m_tlast);
                    error_count++;
                end
            end
        end
    end

    function automatic int slot_at(int pos);
        return (int'(mirror_head) + pos) % QDEPTH;
    endfunction

    function automatic bit key_stored(logic [WORD_W-1:0] k);
        for (int i = 0; i < mirror_count; i++)
        begin
            if (mirror_keys[slot_at(i)] == k)
                return 1'b1;
        end
        return 1'b0;
    endfunction

    // Applies one accepted request to the mirror and queues the results it causes.
    // The duplicate check deliberately comes before the full check.
    function automatic void apply_request(logic [OP_W-1:0] op, logic [WORD_W-1:0] k,
                                          logic [WORD_W-1:0] v);
        int slot;
        if (op == OP_APPEND || op == OP_PREPEND)
        begin
            if (key_stored(k))
                awaited_results.push_back('{ST_DUPLICATE, '0, '0, 1'b1});
            else if (mirror_count >= QDEPTH)
                awaited_results.push_back('{ST_FULL, '0, '0, 1'b1});
            else
            begin
                if (op == OP_APPEND)
                    slot = slot_at(mirror_count);
                else
                begin
                    mirror_head = mirror_head - 1'b1;
                    slot = mirror_head;
                end
                mirror_keys[slot] = k;
                mirror_values[slot] = v;
                mirror_count++;
                awaited_results.push_back('{(op == OP_APPEND) ? ST_APPENDED : ST_PREPENDED,
                                            '0, '0, 1'b1});
            end
        end
        else if (op == OP_DISPLAY)
        begin
            if (mirror_count == 0)
                awaited_results.push_back('{ST_EMPTY, '0, '0, 1'b1});
            for (int i = 0; i < mirror_count; i++)
                awaited_results.push_back('{ST_SHOWN, mirror_keys[slot_at(i)],
                                            mirror_values[slot_at(i)],
                                            (i == mirror_count - 1)});
        end
        // The unused op code changes nothing and owes no result.
    endfunction

    // Presents one request, optionally after a random gap, and waits for it to be taken.
    task automatic send_request(logic [OP_W-1:0] op, logic [WORD_W-1:0] k,
                                logic [WORD_W-1:0] v);
        if (idling_enabled && $urandom_range(0, 3) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {v, k};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        apply_request(op, k, v);
    endtask

    function automatic logic [WORD_W-1:0] fresh_key();
        logic [WORD_W-1:0] k;
        k = $urandom;
        while (key_stored(k))
            k = $urandom;
        return k;
    endfunction

    task automatic test_empty_display();
        send_request(OP_DISPLAY, $urandom, $urandom);
    endtask

    // Extreme keys and data, placed at both ends so the head pointer wraps at once.
    task automatic test_basic_inserts();
        send_request(OP_APPEND,  32'h8000_0000, 32'h7FFF_FFFF);
        send_request(OP_PREPEND, 32'h7FFF_FFFF, 32'h8000_0000);
        send_request(OP_APPEND,  32'h0000_0000, 32'h0000_0000);
        send_request(OP_PREPEND, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    endtask

    task automatic test_duplicates();
        send_request(OP_APPEND,  32'h8000_0000, 32'h1234_5678);
        send_request(OP_PREPEND, 32'h0000_0000, 32'hFFFF_FFFF);
    endtask

    // The spare op code must pass without a result; the display after it shows
    // the contents are untouched.
    task automatic test_ignored_op();
        send_request(OP_UNUSED, 32'hDEAD_BEEF, 32'h0BAD_F00D);
        send_request(OP_DISPLAY, '0, '0);
    endtask

    // Fills every slot, then checks a new key is refused as full and a stored one
    // is still refused as a duplicate, and lists all sixteen entries.
    task automatic test_fill_to_full();
        while (mirror_count < QDEPTH)
            send_request($urandom_range(0, 1) ? OP_APPEND : OP_PREPEND, fresh_key(), $urandom);
        send_request(OP_APPEND, fresh_key(), $urandom);
        send_request(OP_PREPEND, mirror_keys[slot_at(QDEPTH - 1)], $urandom);
        send_request(OP_DISPLAY, $urandom, $urandom);
    endtask

    // Random mix: about a third of inserts reuse a stored key. Since entries are
    // never removed the deque stays full, so this mostly exercises the refusals
    // and long displays under back-pressure; the last stretch runs without idling.
    task automatic test_random_traffic(int n_requests);
        int sent;
        int pick;
        logic [WORD_W-1:0] k;
        sent = 0;
        while (sent < n_requests)
        begin
            if (sent == n_requests - 60)
                idling_enabled = 1'b0;
            pick = $urandom_range(0, 99);
            if (pick < 5)
                send_request(OP_UNUSED, $urandom, $urandom);
            else
            begin
                if (pick < 27)
                    send_request(OP_DISPLAY, $urandom, $urandom);
                else
                begin
                    if (mirror_count > 0 && $urandom_range(0, 2) == 0)
                        k = mirror_keys[slot_at($urandom_range(0, mirror_count - 1))];
                    else
                        k = $urandom;
                    send_request($urandom_range(0, 1) ? OP_APPEND : OP_PREPEND, k, $urandom);
                end
                sent++;
            end
        end
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        idling_enabled = 1'b1;

        test_empty_display();
        test_basic_inserts();
        test_duplicates();
        test_ignored_op();
        test_fill_to_full();
        test_random_traffic(180);
        s_tvalid <= 1'b0;

        // Every owed result must arrive; then stay a while to catch stray extras.
        while (awaited_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

[sim.f]
rtl/ukd_pkg.sv
rtl/ukd_ram.sv
rtl/unique_key_deque_core.sv
sim/tb_unique_key_deque_core.sv
